### rtl/core/d2s_pkg.sv
`timescale 1ns / 1ps

package d2s_pkg;

    // Configuration register indexes on the write port.
    typedef enum logic [2:0] {
        REG_OUT_CHANNELS = 3'd0,
        REG_IN_WIDTH     = 3'd1,
        REG_IN_HEIGHT    = 3'd2,
        REG_IN_DEPTH     = 3'd3,
        REG_BLOCK_SCALE  = 3'd4,
        REG_BATCH_COUNT  = 3'd5
    } reg_index_t;

    localparam int          CFG_DATA_W  = 13;
    localparam int          CFG_INDEX_W = 3;
    localparam logic [12:0] CHAN_MAX    = 13'd4096;
    localparam logic [10:0] DIM_MAX     = 11'd1024;
    localparam int          SCALE_CAP   = 8;

    // Configuration as held in the block, already clamped to the legal range.
    typedef struct packed {
        logic [12:0] out_channels;
        logic [10:0] in_width;
        logic [10:0] in_height;
        logic [10:0] in_depth;
        logic [3:0]  block_scale;
        logic [10:0] batch_count;
    } cfg_t;

    // Position of the next input beat in the tensor, plus a flag for the final beat of the last batch.
    typedef struct packed {
        logic [11:0] chan;
        logic [2:0]  sub_x;
        logic [2:0]  sub_y;
        logic [2:0]  sub_z;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [9:0]  pos_z;
        logic [9:0]  batch;
        logic        last;
    } cnt_t;

endpackage

### rtl/core/d2s_if.sv
`timescale 1ns / 1ps

interface d2s_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

interface d2s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic [31:0] out_address;
    logic        is_last;

    modport source (output valid, output out_word, output out_address, output is_last,
                    input ready);
    modport sink   (input valid, input out_word, input out_address, input is_last,
                    output ready);
endinterface

### rtl/core/d2s_counters.sv
`timescale 1ns / 1ps

module d2s_counters (
    input  logic          clk,
    input  logic          rst_n,
    input  d2s_pkg::cfg_t cfg,
    input  logic          step,
    output d2s_pkg::cnt_t cnt
);
    import d2s_pkg::*;

    logic [11:0] chan_reg,  chan_next;
    logic [2:0]  sub_x_reg, sub_x_next;
    logic [2:0]  sub_y_reg, sub_y_next;
    logic [2:0]  sub_z_reg, sub_z_next;
    logic [9:0]  pos_x_reg, pos_x_next;
    logic [9:0]  pos_y_reg, pos_y_next;
    logic [9:0]  pos_z_reg, pos_z_next;
    logic [9:0]  batch_reg, batch_next;

    logic c_end, x_end, y_end, z_end, px_end, py_end, pz_end, b_end;
    logic cy_c, cy_x, cy_y, cy_z, cy_px, cy_py, cy_pz;
    logic last;

    // A counter at or past its limit counts as sitting on its last value.
    always_comb
    begin
        c_end  = ({1'b0, chan_reg}  + 13'd1) >= cfg.out_channels;
        x_end  = ({1'b0, sub_x_reg} + 4'd1)  >= cfg.block_scale;
        y_end  = ({1'b0, sub_y_reg} + 4'd1)  >= cfg.block_scale;
        z_end  = ({1'b0, sub_z_reg} + 4'd1)  >= cfg.block_scale;
        px_end = ({1'b0, pos_x_reg} + 11'd1) >= cfg.in_width;
        py_end = ({1'b0, pos_y_reg} + 11'd1) >= cfg.in_height;
        pz_end = ({1'b0, pos_z_reg} + 11'd1) >= cfg.in_depth;
        b_end  = ({1'b0, batch_reg} + 11'd1) >= cfg.batch_count;
        last   = c_end && x_end && y_end && z_end && px_end && py_end && pz_end && b_end;

        cy_c  = c_end;
        cy_x  = cy_c && x_end;
        cy_y  = cy_x && y_end;
        cy_z  = cy_y && z_end;
        cy_px = cy_z && px_end;
        cy_py = cy_px && py_end;
        cy_pz = cy_py && pz_end;

        chan_next  = c_end ? 12'd0 : chan_reg + 12'd1;
        sub_x_next = cy_c  ? (x_end  ? 3'd0  : sub_x_reg + 3'd1)  : sub_x_reg;
        sub_y_next = cy_x  ? (y_end  ? 3'd0  : sub_y_reg + 3'd1)  : sub_y_reg;
        sub_z_next = cy_y  ? (z_end  ? 3'd0  : sub_z_reg + 3'd1)  : sub_z_reg;
        pos_x_next = cy_z  ? (px_end ? 10'd0 : pos_x_reg + 10'd1) : pos_x_reg;
        pos_y_next = cy_px ? (py_end ? 10'd0 : pos_y_reg + 10'd1) : pos_y_reg;
        pos_z_next = cy_py ? (pz_end ? 10'd0 : pos_z_reg + 10'd1) : pos_z_reg;
        batch_next = cy_pz ? (b_end  ? 10'd0 : batch_reg + 10'd1) : batch_reg;

        if (last)
        begin
            chan_next  = '0;
            sub_x_next = '0;
            sub_y_next = '0;
            sub_z_next = '0;
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
            batch_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg  <= '0;
            sub_x_reg <= '0;
            sub_y_reg <= '0;
            sub_z_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            batch_reg <= '0;
        end
        else if (step)
        begin
            chan_reg  <= chan_next;
            sub_x_reg <= sub_x_next;
            sub_y_reg <= sub_y_next;
            sub_z_reg <= sub_z_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            batch_reg <= batch_next;
        end
    end

    always_comb
    begin
        cnt.chan  = chan_reg;
        cnt.sub_x = sub_x_reg;
        cnt.sub_y = sub_y_reg;
        cnt.sub_z = sub_z_reg;
        cnt.pos_x = pos_x_reg;
        cnt.pos_y = pos_y_reg;
        cnt.pos_z = pos_z_reg;
        cnt.batch = batch_reg;
        cnt.last  = last;
    end

endmodule

### rtl/core/d2s_addr_pipe.sv
`timescale 1ns / 1ps

module d2s_addr_pipe #(
    parameter int AW = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    output logic             room,
    input  logic [31:0]      word,
    input  d2s_pkg::cnt_t    cnt,
    input  logic [3:0]       scale,
    input  logic [12:0]      chans,
    input  logic [13:0]      out_w,
    input  logic [13:0]      out_h,
    input  logic [AW-1:0]    vol,
    d2s_out_if.source        out_stream
);
    import d2s_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // Stage 1: output voxel coordinates and the batch offset.
    logic [31:0]   s1_word_reg;
    logic          s1_last_reg;
    logic [12:0]   s1_oz_reg, s1_oy_reg, s1_ox_reg;
    logic [AW-1:0] s1_bv_reg;
    logic [11:0]   s1_c_reg;
    // Stage 2: plane row index.
    logic [31:0]   s2_word_reg;
    logic          s2_last_reg;
    logic [AW-1:0] s2_t_reg;
    logic [12:0]   s2_ox_reg;
    logic [AW-1:0] s2_bv_reg;
    logic [11:0]   s2_c_reg;
    // Stage 3: voxel index.
    logic [31:0]   s3_word_reg;
    logic          s3_last_reg;
    logic [AW-1:0] s3_u_reg;
    logic [AW-1:0] s3_bv_reg;
    logic [11:0]   s3_c_reg;
    // Stage 4: final address, which is also the output register.
    logic [31:0]   s4_word_reg;
    logic          s4_last_reg;
    logic [AW-1:0] s4_addr_reg;

    // Each stage may load when it is empty or its contents move on.
    always_comb
    begin
        en4  = !v4_reg || out_stream.ready;
        en3  = !v3_reg || en4;
        en2  = !v2_reg || en3;
        en1  = !v1_reg || en2;
        room = en1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= load;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_word_reg <= word;
            s1_last_reg <= cnt.last;
            s1_oz_reg   <= {3'b0, cnt.pos_z} * {9'b0, scale} + {10'b0, cnt.sub_z};
            s1_oy_reg   <= {3'b0, cnt.pos_y} * {9'b0, scale} + {10'b0, cnt.sub_y};
            s1_ox_reg   <= {3'b0, cnt.pos_x} * {9'b0, scale} + {10'b0, cnt.sub_x};
            s1_bv_reg   <= AW'(cnt.batch) * vol;
            s1_c_reg    <= cnt.chan;
        end
        if (en2)
        begin
            s2_word_reg <= s1_word_reg;
            s2_last_reg <= s1_last_reg;
            s2_t_reg    <= AW'(s1_oz_reg) * AW'(out_h) + AW'(s1_oy_reg);
            s2_ox_reg   <= s1_ox_reg;
            s2_bv_reg   <= s1_bv_reg;
            s2_c_reg    <= s1_c_reg;
        end
        if (en3)
        begin
            s3_word_reg <= s2_word_reg;
            s3_last_reg <= s2_last_reg;
            s3_u_reg    <= s2_t_reg * AW'(out_w) + AW'(s2_ox_reg);
            s3_bv_reg   <= s2_bv_reg;
            s3_c_reg    <= s2_c_reg;
        end
        if (en4)
        begin
            s4_word_reg <= s3_word_reg;
            s4_last_reg <= s3_last_reg;
            s4_addr_reg <= s3_u_reg * AW'(chans) + AW'(s3_c_reg) + s3_bv_reg;
        end
    end

    always_comb
    begin
        out_stream.valid       = v4_reg;
        out_stream.out_word    = s4_word_reg;
        out_stream.out_address = 32'(s4_addr_reg);
        out_stream.is_last     = s4_last_reg;
    end

endmodule

### rtl/core/depth_to_space_3d_address_gen.sv
`timescale 1ns / 1ps

// Channel     Direction  Payload                                Handshake
// ----------  ---------  -------------------------------------  -----------
// in_stream   sink       data_word[31:0]                        valid/ready
// out_stream  source     out_word[31:0], out_address[31:0],     valid/ready
//                        is_last
// cfg port    sink       cfg_index[2:0], cfg_data[12:0]         cfg_wr_en
//
// One beat is accepted per clock while no hold-off is active and the stages have
// room. A beat passes four registered multiply-add stages, and the last one is the
// output register. The position counters add no register to a beat's path. Throughput
// is one beat per cycle when nothing stalls. After a configuration write the input is
// held off while the output volume product is rebuilt through its own chain of
// registered multiplies. rst_n clears the position counters and the stage valid bits,
// and sets every configuration register to 1. The same hold-off follows reset.
// Output stalls back up stage by stage, so bubbles are squeezed out and input is
// still taken while a finished result waits, until every stage is full.

module depth_to_space_3d_address_gen #(
    parameter int ADDR_BITS = 32,
    parameter int MAX_SCALE = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [d2s_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [d2s_pkg::CFG_DATA_W-1:0]       cfg_data,
    d2s_in_if.sink                               in_stream,
    d2s_out_if.source                            out_stream
);
    import d2s_pkg::*;

    // Only the low 32 address bits ever reach the port, and the arithmetic is
    // modular, so the datapath never needs to be wider than that.
    localparam int          AW            = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int          SMAX          = (MAX_SCALE < SCALE_CAP) ? MAX_SCALE : SCALE_CAP;
    localparam logic [3:0]  SCALE_TOP     = 4'(SMAX);
    localparam logic [2:0]  SETTLE_CYCLES = 3'd4;

    cfg_t          cfg_reg, cfg_next;
    logic [2:0]    settle_reg, settle_next;

    // Derived output geometry, recomputed by registered multiplies from the configuration.
    logic [13:0]   ow_reg, oh_reg, od_reg;
    logic [AW-1:0] p1_reg, p2_reg, vol_reg;

    cnt_t          cnt;
    logic          room;
    logic          accept;

    logic [12:0]   v13;
    logic [10:0]   v11;
    logic [3:0]    v4;

    // Registers are stored already clamped: zero reads as one, and anything
    // above the legal range reads as its top, once cut to the register's width.
    always_comb
    begin
        v13 = cfg_data;
        v11 = cfg_data[10:0];
        v4  = cfg_data[3:0];
        if (v13 == 13'd0)
            v13 = 13'd1;
        else if (v13 > CHAN_MAX)
            v13 = CHAN_MAX;
        if (v11 == 11'd0)
            v11 = 11'd1;
        else if (v11 > DIM_MAX)
            v11 = DIM_MAX;
        if (v4 == 4'd0)
            v4 = 4'd1;
        else if (v4 > SCALE_TOP)
            v4 = SCALE_TOP;

        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_OUT_CHANNELS: cfg_next.out_channels = v13;
                REG_IN_WIDTH:     cfg_next.in_width     = v11;
                REG_IN_HEIGHT:    cfg_next.in_height    = v11;
                REG_IN_DEPTH:     cfg_next.in_depth     = v11;
                REG_BLOCK_SCALE:  cfg_next.block_scale  = v4;
                REG_BATCH_COUNT:  cfg_next.batch_count  = v11;
                default:          cfg_next = cfg_reg;
            endcase
        end

        if (cfg_wr_en)
            settle_next = SETTLE_CYCLES;
        else if (settle_reg != 3'd0)
            settle_next = settle_reg - 3'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_channels <= 13'd1;
            cfg_reg.in_width     <= 11'd1;
            cfg_reg.in_height    <= 11'd1;
            cfg_reg.in_depth     <= 11'd1;
            cfg_reg.block_scale  <= 4'd1;
            cfg_reg.batch_count  <= 11'd1;
            settle_reg           <= SETTLE_CYCLES;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            settle_reg <= settle_next;
        end
    end

    // Volume of one output tensor: C * (W*s) * (H*s) * (D*s), one multiply per register.
    always_ff @(posedge clk)
    begin
        ow_reg  <= {3'b0, cfg_reg.in_width}  * {10'b0, cfg_reg.block_scale};
        oh_reg  <= {3'b0, cfg_reg.in_height} * {10'b0, cfg_reg.block_scale};
        od_reg  <= {3'b0, cfg_reg.in_depth}  * {10'b0, cfg_reg.block_scale};
        p1_reg  <= AW'(ow_reg) * AW'(oh_reg);
        p2_reg  <= p1_reg * AW'(od_reg);
        vol_reg <= p2_reg * AW'(cfg_reg.out_channels);
    end

    assign in_stream.ready = room && (settle_reg == 3'd0);
    assign accept          = in_stream.valid && in_stream.ready;

    d2s_counters u_counters (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (accept),
        .cnt   (cnt)
    );

    d2s_addr_pipe #(
        .AW (AW)
    ) u_addr_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .room       (room),
        .word       (in_stream.data_word),
        .cnt        (cnt),
        .scale      (cfg_reg.block_scale),
        .chans      (cfg_reg.out_channels),
        .out_w      (ow_reg),
        .out_h      (oh_reg),
        .vol        (vol_reg),
        .out_stream (out_stream)
    );

`ifndef SYNTHESIS
    // The volume chain must settle before any beat can use it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !in_stream.ready)
        else $error("input accepted while derived geometry was settling");

    // The final beat of the last batch sends every position counter back to the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cnt.last) |=> (cnt.chan == 12'd0 && cnt.sub_x == 3'd0 &&
            cnt.sub_y == 3'd0 && cnt.sub_z == 3'd0 && cnt.pos_x == 10'd0 &&
            cnt.pos_y == 10'd0 && cnt.pos_z == 10'd0 && cnt.batch == 10'd0))
        else $error("counters not cleared after the last beat");

    // Any other accepted beat must move the position somewhere.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cnt.last) |=> (cnt != $past(cnt)))
        else $error("position did not advance on an accepted beat");
`endif

endmodule
